/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle rule");

`endif

/* hw/rtl/slt_pkg.sv */
// Package with token codes, scan modes and keyword tables of the tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package slt_pkg;

	localparam int KIND_BITS   = 6;
	localparam int LEN_BITS    = 16;
	localparam int MAX_TOK     = 4;
	localparam int TOK_IDX_BITS = 2;
	localparam int TOK_CNT_BITS = 3;
	localparam int RAW_TOK     = 6;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [3:0] {
		M_IDLE,
		M_SLASH,
		M_COMMENT,
		M_OPER,
		M_NUMBER,
		M_NUMDOT,
		M_FRACTION,
		M_WORD,
		M_STRING
	} mode_t;

	localparam logic [KIND_BITS-1:0] K_DOT        = 6'd5;
	localparam logic [KIND_BITS-1:0] K_SLASH      = 6'd9;
	localparam logic [KIND_BITS-1:0] K_BANG       = 6'd11;
	localparam logic [KIND_BITS-1:0] K_EQUAL      = 6'd13;
	localparam logic [KIND_BITS-1:0] K_GREATER    = 6'd15;
	localparam logic [KIND_BITS-1:0] K_LESS       = 6'd17;
	localparam logic [KIND_BITS-1:0] K_IDENT      = 6'd19;
	localparam logic [KIND_BITS-1:0] K_STRING     = 6'd20;
	localparam logic [KIND_BITS-1:0] K_NUMBER     = 6'd21;
	localparam logic [KIND_BITS-1:0] K_KEYWORD0   = 6'd22;
	localparam logic [KIND_BITS-1:0] K_ERROR      = 6'd38;
	localparam logic [KIND_BITS-1:0] K_EOF        = 6'd39;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [LEN_BITS-1:0]  len;
	} tok_meta_t;

	// Keywords, space padded to six characters, first character at the top byte.
	localparam logic [47:0] KW_TEXT [16] = '{
		"and   ", "class ", "else  ", "false ", "for   ", "fun   ", "if    ", "nil   ",
		"or    ", "print ", "return", "super ", "this  ", "true  ", "var   ", "while "
	};
	localparam int KW_LEN [16] = '{3, 5, 4, 5, 3, 3, 2, 3, 2, 5, 6, 5, 4, 4, 3, 5};

	// Map a word to its keyword kind, or identifier.
	function automatic logic [KIND_BITS-1:0] kw_kind(input logic [5:0][7:0] p,
			input logic [LEN_BITS-1:0] len);
		logic [KIND_BITS-1:0] k;
		logic hit;
		k = K_IDENT;
		for (int i = 0; i < 16; i++) begin
			hit = (len == LEN_BITS'(KW_LEN[i]));
			for (int j = 0; j < 6; j++) begin
				if (j < KW_LEN[i] && p[j] != KW_TEXT[i][8*(5-j) +: 8])
					hit = 1'b0;
			end
			if (hit)
				k = K_KEYWORD0 + KIND_BITS'(i);
		end
		return k;
	endfunction

	// Kind of a comparison operator, with or without a trailing '='.
	function automatic logic [KIND_BITS-1:0] oper_kind(input logic [7:0] op, input logic eq);
		logic [KIND_BITS-1:0] k;
		case (op)
			8'h21: k = K_BANG;
			8'h3D: k = K_EQUAL;
			8'h3E: k = K_GREATER;
			default: k = K_LESS;
		endcase
		return eq ? k + 6'd1 : k;
	endfunction

	// Kind of a one-character token; error for any byte that starts nothing.
	function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] b);
		logic [KIND_BITS-1:0] k;
		case (b)
			8'h28: k = 6'd0;
			8'h29: k = 6'd1;
			8'h7B: k = 6'd2;
			8'h7D: k = 6'd3;
			8'h2C: k = 6'd4;
			8'h2E: k = K_DOT;
			8'h2D: k = 6'd6;
			8'h2B: k = 6'd7;
			8'h3B: k = 6'd8;
			8'h2F: k = K_SLASH;
			8'h2A: k = 6'd10;
			default: k = K_ERROR;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/slt_front.sv */
// Scanner front end: holds the scan state and turns each byte into a batch of tokens.
`timescale 1ns / 1ps
`default_nettype none
module slt_front #(
	parameter int OFFSET_BITS = 24,
	parameter int LINE_BITS   = 16,
	parameter int KEYWORD_MAX = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [7:0]                    text_byte,
	input  wire logic                          end_of_text,
	input  wire logic                          accept,
	output logic                               bat_valid,
	output logic [slt_pkg::TOK_IDX_BITS-1:0]   bat_last,
	output slt_pkg::tok_meta_t                 bat_meta  [slt_pkg::MAX_TOK],
	output logic [OFFSET_BITS-1:0]             bat_start [slt_pkg::MAX_TOK],
	output logic [LINE_BITS-1:0]               bat_line  [slt_pkg::MAX_TOK]
);
	import slt_pkg::*;

	localparam int PIDX_BITS = $clog2(KEYWORD_MAX);
	localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [LEN_BITS-1:0]    LEN_MAX  = {LEN_BITS{1'b1}};

	mode_t                   mode_q, mode_n;
	logic [7:0]              oper_q, oper_n;
	logic [OFFSET_BITS-1:0]  start_q, start_n;
	logic [OFFSET_BITS-1:0]  pos_q, pos_n;
	logic [LINE_BITS-1:0]    line_q, line_n, line_inc;
	logic [LEN_BITS-1:0]     len_q, len_n;
	logic [7:0]              prefix_q [KEYWORD_MAX];
	logic [7:0]              prefix_n [KEYWORD_MAX];
	logic [5:0][7:0]         word_q, word_n;
	logic                    rescan;

	tok_meta_t               r_meta  [RAW_TOK];
	logic [OFFSET_BITS-1:0]  r_start [RAW_TOK];
	logic [LINE_BITS-1:0]    r_line  [RAW_TOK];
	logic [RAW_TOK-1:0]      r_v;
	logic [TOK_CNT_BITS-1:0] cnt;

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction

	function automatic logic [LEN_BITS-1:0] len_add(input logic [LEN_BITS-1:0] l,
			input logic [1:0] n);
		logic [LEN_BITS:0] s;
		s = {1'b0, l} + (LEN_BITS+1)'(n);
		return s[LEN_BITS] ? LEN_MAX : s[LEN_BITS-1:0];
	endfunction

	// Gather the first six prefix bytes for the keyword compare.
	always_comb begin
		for (int j = 0; j < 6; j++) begin
			word_q[j] = prefix_q[j];
			word_n[j] = prefix_n[j];
		end
	end

	assign pos_n    = (pos_q == OFF_MAX) ? pos_q : pos_q + 1'b1;
	assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;

	// Scan one byte: close the pending token, rescan, and close everything at end of text.
	always_comb begin
		mode_n  = mode_q;
		oper_n  = oper_q;
		start_n = start_q;
		len_n   = len_q;
		line_n  = line_q;
		for (int i = 0; i < KEYWORD_MAX; i++)
			prefix_n[i] = prefix_q[i];
		rescan = 1'b0;
		r_v = '0;
		for (int i = 0; i < RAW_TOK; i++) begin
			r_meta[i]  = '{kind: K_ERROR, len: '0};
			r_start[i] = start_q;
			r_line[i]  = line_q;
		end

		case (mode_q)
			M_IDLE: rescan = 1'b1;
			M_SLASH: begin
				if (text_byte == 8'h2F) begin
					mode_n = M_COMMENT;
				end else begin
					r_v[0] = 1'b1;
					r_meta[0] = '{kind: K_SLASH, len: LEN_BITS'(1)};
					rescan = 1'b1;
				end
			end
			M_COMMENT: begin
				if (text_byte == 8'h0A) begin
					line_n = line_inc;
					mode_n = M_IDLE;
				end
			end
			M_OPER: begin
				r_v[0] = 1'b1;
				if (text_byte == 8'h3D) begin
					r_meta[0] = '{kind: oper_kind(oper_q, 1'b1), len: LEN_BITS'(2)};
					mode_n = M_IDLE;
				end else begin
					r_meta[0] = '{kind: oper_kind(oper_q, 1'b0), len: LEN_BITS'(1)};
					rescan = 1'b1;
				end
			end
			M_NUMBER, M_FRACTION: begin
				if (is_digit(text_byte)) begin
					len_n = len_add(len_q, 2'd1);
				end else if (mode_q == M_NUMBER && text_byte == 8'h2E) begin
					mode_n = M_NUMDOT;
				end else begin
					r_v[0] = 1'b1;
					r_meta[0] = '{kind: K_NUMBER, len: len_q};
					rescan = 1'b1;
				end
			end
			M_NUMDOT: begin
				if (is_digit(text_byte)) begin
					len_n  = len_add(len_q, 2'd2);
					mode_n = M_FRACTION;
				end else begin
					r_v[1:0] = 2'b11;
					r_meta[0] = '{kind: K_NUMBER, len: len_q};
					r_meta[1] = '{kind: K_DOT, len: LEN_BITS'(1)};
					r_start[1] = (pos_q == OFF_MAX) ? OFF_MAX : pos_q - 1'b1;
					rescan = 1'b1;
				end
			end
			M_WORD: begin
				if (is_letter(text_byte) || is_digit(text_byte)) begin
					if (len_q < LEN_BITS'(KEYWORD_MAX))
						prefix_n[len_q[PIDX_BITS-1:0]] = text_byte;
					len_n = len_add(len_q, 2'd1);
				end else begin
					r_v[0] = 1'b1;
					r_meta[0] = '{kind: kw_kind(word_q, len_q), len: len_q};
					rescan = 1'b1;
				end
			end
			M_STRING: begin
				len_n = len_add(len_q, 2'd1);
				if (text_byte == 8'h22) begin
					r_v[0] = 1'b1;
					r_meta[0] = '{kind: K_STRING, len: len_n};
					mode_n = M_IDLE;
				end else if (text_byte == 8'h0A) begin
					line_n = line_inc;
				end
			end
			default: rescan = 1'b1;
		endcase

		// Start a new token from this byte.
		if (rescan) begin
			mode_n  = M_IDLE;
			start_n = pos_q;
			if (text_byte == 8'h20 || text_byte == 8'h09 || text_byte == 8'h0D) begin
				mode_n = M_IDLE;
			end else if (text_byte == 8'h0A) begin
				line_n = line_inc;
			end else if (text_byte == 8'h2F) begin
				mode_n = M_SLASH;
			end else if (is_digit(text_byte)) begin
				mode_n = M_NUMBER;
				len_n  = LEN_BITS'(1);
			end else if (is_letter(text_byte)) begin
				mode_n = M_WORD;
				len_n  = LEN_BITS'(1);
				prefix_n[0] = text_byte;
			end else if (text_byte == 8'h21 || text_byte == 8'h3D ||
					text_byte == 8'h3C || text_byte == 8'h3E) begin
				mode_n = M_OPER;
				oper_n = text_byte;
			end else if (text_byte == 8'h22) begin
				mode_n = M_STRING;
				len_n  = LEN_BITS'(1);
			end else begin
				r_v[2] = 1'b1;
				r_meta[2].kind = single_kind(text_byte);
				r_meta[2].len  = (single_kind(text_byte) == K_ERROR) ? '0 : LEN_BITS'(1);
				r_start[2] = pos_q;
			end
		end
		r_line[2] = line_n;

		// Close the pending token and add the end marker.
		for (int i = 3; i < RAW_TOK; i++) begin
			r_start[i] = start_n;
			r_line[i]  = line_n;
		end
		if (end_of_text) begin
			case (mode_n)
				M_SLASH: begin
					r_v[3] = 1'b1;
					r_meta[3] = '{kind: K_SLASH, len: LEN_BITS'(1)};
				end
				M_OPER: begin
					r_v[3] = 1'b1;
					r_meta[3] = '{kind: oper_kind(oper_n, 1'b0), len: LEN_BITS'(1)};
				end
				M_NUMBER, M_FRACTION: begin
					r_v[3] = 1'b1;
					r_meta[3] = '{kind: K_NUMBER, len: len_n};
				end
				M_NUMDOT: begin
					r_v[4:3] = 2'b11;
					r_meta[3] = '{kind: K_NUMBER, len: len_n};
					r_meta[4] = '{kind: K_DOT, len: LEN_BITS'(1)};
					r_start[4] = (pos_n == OFF_MAX) ? OFF_MAX : pos_n - 1'b1;
				end
				M_WORD: begin
					r_v[3] = 1'b1;
					r_meta[3] = '{kind: kw_kind(word_n, len_n), len: len_n};
				end
				M_STRING: begin
					r_v[3] = 1'b1;
					r_meta[3] = '{kind: K_ERROR, len: '0};
				end
				default: r_v[3] = 1'b0;
			endcase
			r_v[5] = 1'b1;
			r_meta[5] = '{kind: K_EOF, len: '0};
			r_start[5] = pos_n;
		end
	end

	// Pack the raw tokens into consecutive batch slots.
	always_comb begin
		cnt = '0;
		for (int i = 0; i < MAX_TOK; i++) begin
			bat_meta[i]  = r_meta[RAW_TOK-1];
			bat_start[i] = r_start[RAW_TOK-1];
			bat_line[i]  = r_line[RAW_TOK-1];
		end
		for (int r = 0; r < RAW_TOK; r++) begin
			if (r_v[r] && cnt < TOK_CNT_BITS'(MAX_TOK)) begin
				bat_meta[cnt[TOK_IDX_BITS-1:0]]  = r_meta[r];
				bat_start[cnt[TOK_IDX_BITS-1:0]] = r_start[r];
				bat_line[cnt[TOK_IDX_BITS-1:0]]  = r_line[r];
				cnt = cnt + 1'b1;
			end
		end
	end

	assign bat_valid = accept && (cnt != '0);
	assign bat_last  = TOK_IDX_BITS'(cnt - 1'b1);

	// Advance the scan state on each accepted item; end of text returns to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			oper_q  <= '0;
			start_q <= '0;
			pos_q   <= '0;
			line_q  <= LINE_BITS'(1);
			len_q   <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				mode_q  <= M_IDLE;
				oper_q  <= '0;
				start_q <= '0;
				pos_q   <= '0;
				line_q  <= LINE_BITS'(1);
				len_q   <= '0;
			end else begin
				mode_q  <= mode_n;
				oper_q  <= oper_n;
				start_q <= start_n;
				pos_q   <= pos_n;
				line_q  <= line_n;
				len_q   <= len_n;
			end
		end
	end

	// Hold the word prefix; entries are read only after the current word wrote them.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < KEYWORD_MAX; i++)
				prefix_q[i] <= prefix_n[i];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/slt_back.sv */
// Token back end: queues token batches and delivers them one item at a time.
`timescale 1ns / 1ps
`default_nettype none
module slt_back #(
	parameter int OFFSET_BITS = 24,
	parameter int LINE_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          bat_valid,
	input  wire logic [slt_pkg::TOK_IDX_BITS-1:0] bat_last,
	input  wire slt_pkg::tok_meta_t            bat_meta  [slt_pkg::MAX_TOK],
	input  wire logic [OFFSET_BITS-1:0]        bat_start [slt_pkg::MAX_TOK],
	input  wire logic [LINE_BITS-1:0]          bat_line  [slt_pkg::MAX_TOK],
	output logic                               full,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [slt_pkg::KIND_BITS-1:0]      token_kind,
	output logic [OFFSET_BITS-1:0]             start_offset,
	output logic [slt_pkg::LEN_BITS-1:0]       token_length,
	output logic [LINE_BITS-1:0]               line_number,
	output logic                               last_of_run
);
	import slt_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	tok_meta_t              q_meta  [QUEUE_DEPTH][MAX_TOK];
	logic [OFFSET_BITS-1:0] q_start [QUEUE_DEPTH][MAX_TOK];
	logic [LINE_BITS-1:0]   q_line  [QUEUE_DEPTH][MAX_TOK];
	logic [TOK_IDX_BITS-1:0] q_last [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]    wr_q, rd_q;
	logic [CNT_BITS-1:0]    count_q;
	logic [TOK_IDX_BITS-1:0] sub_q;
	logic                   take, batch_done;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign take  = pop && !empty;
	assign batch_done = take && (sub_q == q_last[rd_q]);

	// Show the current item of the oldest batch.
	assign token_kind   = q_meta[rd_q][sub_q].kind;
	assign token_length = q_meta[rd_q][sub_q].len;
	assign start_offset = q_start[rd_q][sub_q];
	assign line_number  = q_line[rd_q][sub_q];
	assign last_of_run  = (sub_q == q_last[rd_q]);

	// Store incoming batches.
	always_ff @(posedge clk) begin
		if (bat_valid) begin
			q_last[wr_q] <= bat_last;
			for (int i = 0; i < MAX_TOK; i++) begin
				q_meta[wr_q][i]  <= bat_meta[i];
				q_start[wr_q][i] <= bat_start[i];
				q_line[wr_q][i]  <= bat_line[i];
			end
		end
	end

	// Advance pointers, fill count and the position inside the head batch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
			sub_q   <= '0;
		end else begin
			if (bat_valid)
				wr_q <= wr_q + 1'b1;
			if (batch_done) begin
				rd_q  <= rd_q + 1'b1;
				sub_q <= '0;
			end else if (take) begin
				sub_q <= sub_q + 1'b1;
			end
			count_q <= count_q + CNT_BITS'(bat_valid) - CNT_BITS'(batch_done);
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/script_language_tokenizer_core.sv */
// Top level of the streaming tokenizer: scanner front end and token queue.
//
// The block takes one source byte per cycle and produces the tokens of a small
// scripting language. Each accepted byte yields zero to four tokens, delivered
// one per pop in source order, the last one of a byte flagged by last_of_run. The
// scanner closes a token within the cycle its byte is accepted, so a byte can be
// pushed every cycle; bytes keep flowing while the token queue has room for a
// further batch (four batches). Sustained throughput is one byte per cycle as long
// as the consumer pops at least as many tokens as the source produces; a byte that
// yields n tokens takes n pops on the output side. After the byte marked
// end_of_text the EOF token is emitted and the scan restarts at offset 0, line 1.
`timescale 1ns / 1ps
`default_nettype none
module script_language_tokenizer_core #(
	parameter int OFFSET_BITS = 24,
	parameter int LINE_BITS   = 16,
	parameter int KEYWORD_MAX = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [7:0]                  text_byte,
	input  wire logic                        end_of_text,
	input  wire logic                        push,
	output logic                             full,
	output logic [slt_pkg::KIND_BITS-1:0]    token_kind,
	output logic [OFFSET_BITS-1:0]           start_offset,
	output logic [slt_pkg::LEN_BITS-1:0]     token_length,
	output logic [LINE_BITS-1:0]             line_number,
	output logic                             last_of_run,
	output logic                             empty,
	input  wire logic                        pop
);
	import slt_pkg::*;

	logic                     accept;
	logic                     bat_valid;
	logic [TOK_IDX_BITS-1:0]  bat_last;
	tok_meta_t                bat_meta  [MAX_TOK];
	logic [OFFSET_BITS-1:0]   bat_start [MAX_TOK];
	logic [LINE_BITS-1:0]     bat_line  [MAX_TOK];

	assign accept = push && !full;

	// Scan bytes into token batches.
	slt_front #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS  (LINE_BITS),
		.KEYWORD_MAX(KEYWORD_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.accept     (accept),
		.bat_valid  (bat_valid),
		.bat_last   (bat_last),
		.bat_meta   (bat_meta),
		.bat_start  (bat_start),
		.bat_line   (bat_line)
	);

	// Queue batches and hand out tokens.
	slt_back #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS  (LINE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.bat_valid   (bat_valid),
		.bat_last    (bat_last),
		.bat_meta    (bat_meta),
		.bat_start   (bat_start),
		.bat_line    (bat_line),
		.full        (full),
		.empty       (empty),
		.pop         (pop),
		.token_kind  (token_kind),
		.start_offset(start_offset),
		.token_length(token_length),
		.line_number (line_number),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire

/* hw/rtl/slt_checker.sv */
// Port-level checks of the tokenizer and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module slt_checker #(
	parameter int OFFSET_BITS = 24,
	parameter int LINE_BITS   = 16
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         push,
	input wire logic                         full,
	input wire logic                         end_of_text,
	input wire logic                         empty,
	input wire logic                         pop,
	input wire logic [slt_pkg::KIND_BITS-1:0] token_kind,
	input wire logic [OFFSET_BITS-1:0]       start_offset,
	input wire logic [slt_pkg::LEN_BITS-1:0] token_length,
	input wire logic [LINE_BITS-1:0]         line_number,
	input wire logic                         last_of_run
);
	import slt_pkg::*;

	// Error and end tokens carry no lexeme.
	`SLT_ASSERT_NOW(a_zero_len, clk, arst_n, !empty && (token_kind == K_ERROR || token_kind == K_EOF), token_length == '0)
	// The end token closes the run of its byte.
	`SLT_ASSERT_NOW(a_eof_last, clk, arst_n, !empty && token_kind == K_EOF, last_of_run)
	// The last byte of a source always leaves at least its end token waiting.
	`SLT_ASSERT_NEXT(a_eof_queued, clk, arst_n, push && !full && end_of_text, !empty)
	// A waiting item holds until it is taken.
	`SLT_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(start_offset) && $stable(line_number))

endmodule

bind script_language_tokenizer_core slt_checker #(
	.OFFSET_BITS(OFFSET_BITS),
	.LINE_BITS  (LINE_BITS)
) u_slt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.push        (push),
	.full        (full),
	.end_of_text (end_of_text),
	.empty       (empty),
	.pop         (pop),
	.token_kind  (token_kind),
	.start_offset(start_offset),
	.token_length(token_length),
	.line_number (line_number),
	.last_of_run (last_of_run)
);
`default_nettype wire

/* tb/script_language_tokenizer_core_tb.sv */
// Testbench for the streaming tokenizer: token predictor, scoreboard and queue-side drivers.
`timescale 1ns / 1ps
`default_nettype none
module script_language_tokenizer_core_tb;
	import slt_pkg::*;

	localparam int OFF_W = 24;
	localparam int LINE_W = 16;
	localparam int KW_MAX = 6;
	localparam logic [OFF_W-1:0] OFF_TOP = '1;
	localparam logic [LINE_W-1:0] LINE_TOP = '1;
	localparam int unsigned LEN_TOP = 65535;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [OFF_W-1:0]     start;
		logic [LEN_BITS-1:0]  len;
		logic [LINE_W-1:0]    line;
		logic                 last;
	} token_t;

	// Predict tokens from accepted bytes and match them against popped tokens.
	class TokenScoreboard;
		mode_t mode;
		logic [7:0] op_char;
		logic [OFF_W-1:0] tok_start;
		logic [OFF_W-1:0] next_pos;
		logic [LINE_W-1:0] line;
		logic [7:0] prefix [KW_MAX];
		int unsigned lex_len;
		token_t pending_tokens[$];
		token_t batch[$];
		int mismatches;
		int tokens_seen;
		int bytes_seen;
		int sources_done;
		string kw_words [16];

		function new();
			kw_words = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
				"or", "print", "return", "super", "this", "true", "var", "while"};
			clear_scan();
			mismatches = 0;
			tokens_seen = 0;
			bytes_seen = 0;
			sources_done = 0;
		endfunction

		function void clear_scan();
			mode = M_IDLE;
			op_char = 8'd0;
			tok_start = '0;
			next_pos = '0;
			line = LINE_W'(1);
			lex_len = 0;
			foreach (prefix[i]) prefix[i] = 8'd0;
		endfunction

		function void add_token(logic [KIND_BITS-1:0] k, logic [OFF_W-1:0] s, int unsigned n);
			token_t t;
			if (batch.size() >= MAX_TOK)
				return;
			t.kind = k;
			t.start = s;
			t.len = n[LEN_BITS-1:0];
			t.line = line;
			t.last = 1'b0;
			batch.push_back(t);
		endfunction

		function bit is_num(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function bit is_alpha(logic [7:0] b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
		endfunction

		function void bump_line();
			if (line != LINE_TOP)
				line++;
		endfunction

		function void grow(int unsigned n);
			lex_len += n;
			if (lex_len > LEN_TOP)
				lex_len = LEN_TOP;
		endfunction

		function logic [KIND_BITS-1:0] compare_kind(logic [7:0] op, bit with_eq);
			logic [KIND_BITS-1:0] k;
			case (op)
				"!": k = K_BANG;
				"=": k = K_EQUAL;
				">": k = K_GREATER;
				default: k = K_LESS;
			endcase
			return with_eq ? k + 1'b1 : k;
		endfunction

		// Classify the pending word against the keyword list.
		function void close_word();
			logic [KIND_BITS-1:0] k;
			bit same;
			k = K_IDENT;
			if (lex_len <= KW_MAX) begin
				for (int i = 0; i < 16; i++) begin
					same = (kw_words[i].len() == lex_len);
					for (int j = 0; j < kw_words[i].len() && same; j++)
						if (prefix[j] != kw_words[i][j])
							same = 0;
					if (same) begin
						k = K_KEYWORD0 + KIND_BITS'(i);
						break;
					end
				end
			end
			add_token(k, tok_start, lex_len);
		endfunction

		function void close_number_dot(logic [OFF_W-1:0] p);
			add_token(K_NUMBER, tok_start, lex_len);
			add_token(K_DOT, (p == OFF_TOP) ? OFF_TOP : p - 1'b1, 1);
		endfunction

		// Start a new token, or skip the byte.
		function void begin_token(logic [7:0] b, logic [OFF_W-1:0] p);
			string singles;
			singles = "(){},.-+;/*";
			mode = M_IDLE;
			tok_start = p;
			if (b == " " || b == 8'h09 || b == 8'h0D)
				return;
			if (b == 8'h0A) begin
				bump_line();
				return;
			end
			if (b == "/") begin
				mode = M_SLASH;
				return;
			end
			if (is_num(b)) begin
				mode = M_NUMBER;
				lex_len = 1;
				return;
			end
			if (is_alpha(b)) begin
				mode = M_WORD;
				lex_len = 1;
				prefix[0] = b;
				return;
			end
			if (b == "!" || b == "=" || b == "<" || b == ">") begin
				mode = M_OPER;
				op_char = b;
				return;
			end
			if (b == 8'h22) begin
				mode = M_STRING;
				lex_len = 1;
				return;
			end
			for (int i = 0; i < singles.len(); i++)
				if (singles[i] == b) begin
					add_token(KIND_BITS'(i), p, 1);
					return;
				end
			add_token(K_ERROR, p, 0);
		endfunction

		function void close_pending(logic [OFF_W-1:0] p);
			case (mode)
				M_SLASH: add_token(K_SLASH, tok_start, 1);
				M_OPER: add_token(compare_kind(op_char, 0), tok_start, 1);
				M_NUMBER, M_FRACTION: add_token(K_NUMBER, tok_start, lex_len);
				M_NUMDOT: close_number_dot(p);
				M_WORD: close_word();
				M_STRING: add_token(K_ERROR, tok_start, 0);
				default: ;
			endcase
		endfunction

		// Note an accepted byte and queue the tokens it produces.
		function void note_byte(logic [7:0] b, bit eot);
			logic [OFF_W-1:0] p;
			bit again;
			p = next_pos;
			again = 0;
			batch.delete();
			bytes_seen++;
			if (next_pos != OFF_TOP)
				next_pos++;
			case (mode)
				M_IDLE: again = 1;
				M_SLASH:
					if (b == "/")
						mode = M_COMMENT;
					else begin
						add_token(K_SLASH, tok_start, 1);
						again = 1;
					end
				M_COMMENT:
					if (b == 8'h0A) begin
						bump_line();
						mode = M_IDLE;
					end
				M_OPER:
					if (b == "=") begin
						add_token(compare_kind(op_char, 1), tok_start, 2);
						mode = M_IDLE;
					end else begin
						add_token(compare_kind(op_char, 0), tok_start, 1);
						again = 1;
					end
				M_NUMBER:
					if (is_num(b))
						grow(1);
					else if (b == ".")
						mode = M_NUMDOT;
					else begin
						add_token(K_NUMBER, tok_start, lex_len);
						again = 1;
					end
				M_NUMDOT:
					if (is_num(b)) begin
						grow(2);
						mode = M_FRACTION;
					end else begin
						close_number_dot(p);
						again = 1;
					end
				M_FRACTION:
					if (is_num(b))
						grow(1);
					else begin
						add_token(K_NUMBER, tok_start, lex_len);
						again = 1;
					end
				M_WORD:
					if (is_alpha(b) || is_num(b)) begin
						if (lex_len < KW_MAX)
							prefix[lex_len] = b;
						grow(1);
					end else begin
						close_word();
						again = 1;
					end
				M_STRING: begin
					grow(1);
					if (b == 8'h22) begin
						add_token(K_STRING, tok_start, lex_len);
						mode = M_IDLE;
					end else if (b == 8'h0A)
						bump_line();
				end
				default: again = 1;
			endcase
			if (again)
				begin_token(b, p);
			if (eot) begin
				close_pending(next_pos);
				add_token(K_EOF, next_pos, 0);
				clear_scan();
				sources_done++;
			end
			if (batch.size() > 0)
				batch[batch.size()-1].last = 1'b1;
			foreach (batch[i])
				pending_tokens.push_back(batch[i]);
		endfunction

		// Compare a popped token with the oldest expected one.
		function void check_token(token_t got);
			token_t want;
			if (pending_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token: kind %0d start %0d len %0d line %0d last %0b",
						got.kind, got.start, got.len, got.line, got.last);
				return;
			end
			want = pending_tokens.pop_front();
			tokens_seen++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("token %0d mismatch", tokens_seen);
					$display("  expected kind %0d start %0d len %0d line %0d last %0b",
						want.kind, want.start, want.len, want.line, want.last);
					$display("  actual   kind %0d start %0d len %0d line %0d last %0b",
						got.kind, got.start, got.len, got.line, got.last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic [7:0] text_byte;
	logic end_of_text;
	logic push;
	logic full;
	logic [KIND_BITS-1:0] token_kind;
	logic [OFF_W-1:0] start_offset;
	logic [LEN_BITS-1:0] token_length;
	logic [LINE_W-1:0] line_number;
	logic last_of_run;
	logic empty;
	logic pop;

	TokenScoreboard sb;
	int bytes_sent;
	int burst_left;
	int stall_cycles;
	bit long_hold_done;
	int full_cycles;
	byte unsigned src[$];

	script_language_tokenizer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.push(push),
		.full(full),
		.token_kind(token_kind),
		.start_offset(start_offset),
		.token_length(token_length),
		.line_number(line_number),
		.last_of_run(last_of_run),
		.empty(empty),
		.pop(pop)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// End the run if it hangs.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// Pop with a shifting pattern; hold off once for a long stretch mid-run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			stall_cycles <= 0;
			long_hold_done <= 1'b0;
		end else if (stall_cycles > 0) begin
			pop <= 1'b0;
			stall_cycles <= stall_cycles - 1;
		end else if (!long_hold_done && bytes_sent >= 90) begin
			pop <= 1'b0;
			long_hold_done <= 1'b1;
			stall_cycles <= 80;
		end else begin
			case ((bytes_sent / 25) % 4)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 2) == 0);
				2: pop <= 1'($urandom_range(0, 1));
				default: begin
					pop <= 1'b1;
					if ($urandom_range(0, 15) == 0)
						stall_cycles <= $urandom_range(2, 12);
				end
			endcase
		end
	end

	// Check each token as it is popped.
	always @(negedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_token({token_kind, start_offset, token_length, line_number, last_of_run});
		if (arst_n && push && full)
			full_cycles++;
	end

	// Offer one item and hold it until the block takes it.
	task automatic send_byte(input logic [7:0] b, input bit eot);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		text_byte <= b;
		end_of_text <= eot;
		forever begin
			@(negedge clk);
			if (!full)
				break;
			@(posedge clk);
		end
		sb.note_byte(b, eot);
		bytes_sent++;
		@(posedge clk);
	endtask

	// Send the collected source, end flag on its last byte when asked.
	task automatic send_source(input bit close);
		foreach (src[i])
			send_byte(src[i], close && (i == src.size() - 1));
		src.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			src.push_back(s[i]);
	endtask

	// Append one random lexeme, mostly well formed.
	task automatic add_lexeme();
		string kw [16];
		string s;
		kw = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
			"or", "print", "return", "super", "this", "true", "var", "while"};
		case ($urandom_range(0, 13))
			0, 1: add_text(kw[$urandom_range(0, 15)]);
			2: begin
				s = kw[$urandom_range(0, 15)];
				add_text(s.substr(0, $urandom_range(0, s.len() - 1)));
				if ($urandom_range(0, 1))
					add_text("x9");
			end
			3: begin
				src.push_back(8'("a" + $urandom_range(0, 25)));
				repeat ($urandom_range(0, 9))
					src.push_back($urandom_range(0, 2) ? 8'("A" + $urandom_range(0, 25))
						: 8'("0" + $urandom_range(0, 9)));
			end
			4, 5: begin
				repeat ($urandom_range(1, 4)) src.push_back(8'("0" + $urandom_range(0, 9)));
				case ($urandom_range(0, 2))
					0: begin
						src.push_back(".");
						repeat ($urandom_range(1, 3))
							src.push_back(8'("0" + $urandom_range(0, 9)));
					end
					1: src.push_back(".");
					default: ;
				endcase
			end
			6: begin
				src.push_back(8'h22);
				repeat ($urandom_range(0, 6))
					src.push_back($urandom_range(0, 5) == 0 ? 8'h0A
						: 8'("a" + $urandom_range(0, 25)));
				src.push_back(8'h22);
			end
			7: begin
				s = "!=<>";
				src.push_back(s[$urandom_range(0, 3)]);
				if ($urandom_range(0, 1))
					src.push_back("=");
			end
			8: begin
				s = "(){},.-+;/*";
				src.push_back(s[$urandom_range(0, s.len() - 1)]);
			end
			9: begin
				add_text("//");
				repeat ($urandom_range(0, 4)) src.push_back(8'($urandom_range(32, 126)));
				src.push_back(8'h0A);
			end
			10: add_text("// a\n//b\n");
			11: src.push_back(8'($urandom_range(0, 255)));
			default: begin
				s = " \t\r\n";
				src.push_back(s[$urandom_range(0, 3)]);
			end
		endcase
		if ($urandom_range(0, 2) == 0)
			src.push_back($urandom_range(0, 1) ? " " : 8'h0A);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		text_byte = 8'd0;
		end_of_text = 1'b0;
		bytes_sent = 0;
		burst_left = 0;
		full_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: keyword, string with newline, number then dot, operators,
		// bad bytes, and a pending string, comment, number with dot and slash cut off by the end flag.
		add_text("fun\"a\n\"3.x!=<@");
		src.push_back(8'h00);
		src.push_back(8'hFF);
		send_source(1);
		add_text("\"ab");
		send_source(1);
		add_text("//c");
		send_source(1);
		add_text("7.");
		send_source(1);
		add_text("/");
		send_source(1);

		// Pause until the block has drained.
		push <= 1'b0;
		do @(negedge clk); while (sb.pending_tokens.size() != 0);
		@(posedge clk);

		// Random sources of well-formed lexemes with some noise.
		while (bytes_sent < 140) begin
			repeat ($urandom_range(2, 12)) add_lexeme();
			send_source($urandom_range(0, 5) != 0);
		end
		add_text("end");
		send_source(1);
		push <= 1'b0;

		// Drain, then allow for stray tokens.
		do @(negedge clk); while (sb.pending_tokens.size() != 0);
		repeat (30) @(posedge clk);

		$display("Covered %0d bytes in %0d sources, %0d tokens checked,",
			sb.bytes_seen, sb.sources_done, sb.tokens_seen);
		$display("  %0d cycles with input stalled.", full_cycles);
		if (sb.mismatches == 0 && sb.pending_tokens.size() == 0)
			$display("SUCCESS");
		else begin
			$display("%0d mismatches", sb.mismatches);
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
+incdir+hw/rtl
hw/rtl/slt_pkg.sv
hw/rtl/slt_front.sv
hw/rtl/slt_back.sv
hw/rtl/script_language_tokenizer_core.sv
hw/rtl/slt_checker.sv
tb/script_language_tokenizer_core_tb.sv
